// File: src/wlfa_pkg.sv
// ----------------------------------------------------------------------------
// Line fit accumulator package
// Shared types, register indexes, constants and the saturating adder.
// ----------------------------------------------------------------------------
package wlfa_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int MAX_HITS_DEF  = 255;
  localparam int PROD_W        = 129;
  localparam int QUOT_W        = 33;
  localparam int CMD_DEPTH     = 2;
  localparam int CFG_IDX_W     = 8;
  localparam int CFG_DATA_W    = 8;

  localparam logic [7:0] MIN_HITS_RST = 8'd3;
  localparam logic       SZ_EN_RST    = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_HITS  = 8'd0,
    REG_SZ_ENABLE = 8'd1
  } cfg_reg_t;

  typedef struct packed {
    logic               start_track;
    logic        [31:0] xy_weight;
    logic signed [31:0] conf_x;
    logic signed [31:0] conf_y;
    logic        [31:0] sz_weight;
    logic signed [31:0] path_len;
    logic signed [31:0] z_pos;
  } hit_t;

  typedef struct packed {
    logic signed [31:0] xy_intercept;
    logic signed [31:0] xy_slope;
    logic signed [31:0] sz_intercept;
    logic signed [31:0] sz_slope;
    logic               xy_singular;
    logic               sz_singular;
    logic               fit_solved;
    logic        [7:0]  hits_so_far;
  } fit_t;

  typedef struct packed {
    logic       start;
    logic       acc;
    logic       solving;
    logic       sz_en;
    logic [7:0] hits;
    hit_t       hit;
  } cmd_t;

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if ((a[63] == b[63]) && (s[63] != a[63])) begin
      sat_add64 = a[63] ? {1'b1, {63{1'b0}}} : {1'b0, {63{1'b1}}};
    end else begin
      sat_add64 = s;
    end
  endfunction

endpackage

// File: src/wlfa_front.sv
// ----------------------------------------------------------------------------
// Line fit front end
// Holds configuration and the hit count, and classifies each accepted hit.
// ----------------------------------------------------------------------------
module wlfa_front #(
  parameter int MAX_HITS = wlfa_pkg::MAX_HITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  wlfa_pkg::hit_t                       hit,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [wlfa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wlfa_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                 q_push,
  input  logic                                 q_full,
  output wlfa_pkg::cmd_t                       cmd
);
  import wlfa_pkg::*;

  localparam int CNT_W = $clog2(MAX_HITS + 1);
  localparam int EXT_W = (CNT_W > 8) ? CNT_W : 8;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_HITS);

  logic [CNT_W-1:0] hit_count;
  logic [CNT_W-1:0] hit_count_next;
  logic [CNT_W-1:0] base_count;
  logic [7:0]       min_hits;
  logic             sz_enable;
  logic [EXT_W-1:0] count_ext;
  logic [EXT_W-1:0] min_ext;
  logic             accept;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign accept    = push && !q_full;
  assign q_push    = accept;

  always_comb begin
    base_count     = hit.start_track ? '0 : hit_count;
    hit_count_next = (base_count < CNT_MAX) ? base_count + 1'b1 : base_count;
    count_ext      = EXT_W'(hit_count_next);
    min_ext        = EXT_W'(min_hits);
    cmd.start      = hit.start_track;
    cmd.acc        = count_ext >= min_ext;
    cmd.solving    = count_ext > min_ext;
    cmd.sz_en      = sz_enable;
    cmd.hits       = (count_ext > EXT_W'(8'hFF)) ? 8'hFF : count_ext[7:0];
    cmd.hit        = hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_count <= '0;
      min_hits  <= MIN_HITS_RST;
      sz_enable <= SZ_EN_RST;
    end else begin
      if (accept) begin
        hit_count <= hit_count_next;
      end
      if (cfg_valid) begin
        case (cfg_index)
          REG_MIN_HITS:  min_hits  <= cfg_data[7:0];
          REG_SZ_ENABLE: sz_enable <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

endmodule

// File: src/wlfa_queue.sv
// ----------------------------------------------------------------------------
// Line fit command queue
// Short queue of classified hits between the front end and the solver.
// ----------------------------------------------------------------------------
module wlfa_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  wlfa_pkg::cmd_t din,
  input  logic           pop,
  output logic           empty,
  output wlfa_pkg::cmd_t dout
);
  import wlfa_pkg::*;

  localparam int AW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CW = $clog2(CMD_DEPTH + 1);

  cmd_t          mem [CMD_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push_ok;
  logic          pop_ok;

  function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
    nxt = (p == AW'(CMD_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full    = (count == CW'(CMD_DEPTH));
  assign empty   = (count == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= nxt(wr_ptr);
      end
      if (pop_ok) begin
        rd_ptr <= nxt(rd_ptr);
      end
      case ({push_ok, pop_ok})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

// File: src/wlfa_mul.sv
// ----------------------------------------------------------------------------
// Line fit multiplier
// Signed 64 by 64 multiply in sign-magnitude form, one 32 by 32 partial
// product per cycle.
// ----------------------------------------------------------------------------
module wlfa_mul (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic               done,
  output logic [127:0]       mag,
  output logic               neg
);

  logic [63:0]  am;
  logic [63:0]  bm;
  logic [127:0] acc;
  logic [1:0]   k;
  logic         busy;
  logic [31:0]  a_part;
  logic [31:0]  b_part;
  logic [63:0]  pp;
  logic [127:0] pp_sh;

  assign a_part = k[1] ? am[63:32] : am[31:0];
  assign b_part = k[0] ? bm[63:32] : bm[31:0];
  assign pp     = a_part * b_part;
  assign mag    = acc;

  always_comb begin
    case (k)
      2'd0:    pp_sh = {64'b0, pp};
      2'd3:    pp_sh = {pp, 64'b0};
      default: pp_sh = {32'b0, pp, 32'b0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      k    <= '0;
    end else begin
      done <= !start && busy && (k == 2'd3);
      if (start) begin
        busy <= 1'b1;
        k    <= '0;
      end else if (busy) begin
        k <= k + 1'b1;
        if (k == 2'd3) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      am  <= a[63] ? 64'(-a) : a;
      bm  <= b[63] ? 64'(-b) : b;
      neg <= a[63] ^ b[63];
      acc <= '0;
    end else if (busy) begin
      acc <= acc + pp_sh;
    end
  end

endmodule

// File: src/wlfa_div.sv
// ----------------------------------------------------------------------------
// Line fit divider
// Restoring division of a scaled numerator by the determinant, one quotient
// bit per cycle, with a fixed latency and a saturated 32-bit result.
// ----------------------------------------------------------------------------
module wlfa_div #(
  parameter int FRAC_BITS = wlfa_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [wlfa_pkg::PROD_W-1:0]  num,
  input  logic signed [wlfa_pkg::PROD_W-1:0]  den,
  output logic                                done,
  output logic signed [31:0]                  quot
);
  import wlfa_pkg::*;

  localparam int NW     = PROD_W + FRAC_BITS;
  localparam int KW0    = PROD_W + QUOT_W;
  localparam int CW     = (NW > KW0) ? NW : KW0;
  localparam int KCNT_W = $clog2(QUOT_W + 1);

  logic [PROD_W-1:0] num_mag;
  logic [PROD_W-1:0] den_mag;
  logic [CW-1:0]     rem;
  logic [CW-1:0]     dk;
  logic [CW-1:0]     dk_half;
  logic [QUOT_W-1:0] q;
  logic [QUOT_W-1:0] qs;
  logic [KCNT_W-1:0] k;
  logic              ovf;
  logic              neg;
  logic              busy;
  logic              first;

  assign num_mag = num[PROD_W-1] ? PROD_W'(-num) : num;
  assign den_mag = den[PROD_W-1] ? PROD_W'(-den) : den;
  assign dk_half = dk >> 1;
  assign qs      = ovf ? '1 : q;

  always_comb begin
    if (neg) begin
      if (qs[QUOT_W-1] || (qs[31] && (|qs[30:0]))) begin
        quot = {1'b1, 31'b0};
      end else begin
        quot = -qs[31:0];
      end
    end else begin
      if (qs[QUOT_W-1] || qs[31]) begin
        quot = {1'b0, {31{1'b1}}};
      end else begin
        quot = qs[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      first <= 1'b0;
      k     <= '0;
    end else begin
      done <= !start && busy && !first && (k == KCNT_W'(QUOT_W - 1));
      if (start) begin
        busy  <= 1'b1;
        first <= 1'b1;
        k     <= '0;
      end else if (busy) begin
        if (first) begin
          first <= 1'b0;
        end else begin
          k <= k + 1'b1;
          if (k == KCNT_W'(QUOT_W - 1)) begin
            busy <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= CW'(num_mag) << FRAC_BITS;
      dk  <= CW'(den_mag) << QUOT_W;
      neg <= num[PROD_W-1] ^ den[PROD_W-1];
      q   <= '0;
      ovf <= 1'b0;
    end else if (busy) begin
      if (first) begin
        ovf <= (rem >= dk);
      end else begin
        dk <= dk_half;
        if (rem >= dk_half) begin
          rem <= rem - dk_half;
          q   <= {q[QUOT_W-2:0], 1'b1};
        end else begin
          q   <= {q[QUOT_W-2:0], 1'b0};
        end
      end
    end
  end

endmodule

// File: src/wlfa_back.sv
// ----------------------------------------------------------------------------
// Line fit back end
// Sequences moment accumulation and the 2x2 solve for each plane through a
// shared multiplier and two dividers, and holds the result register.
// ----------------------------------------------------------------------------
module wlfa_back #(
  parameter int FRAC_BITS = wlfa_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  output logic           q_pop,
  input  wlfa_pkg::cmd_t cmd,
  output logic           empty,
  input  logic           pop,
  output wlfa_pkg::fit_t fit
);
  import wlfa_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_ISSUE  = 7'b0000010,
    S_MUL    = 7'b0000100,
    S_POST   = 7'b0001000,
    S_DSTART = 7'b0010000,
    S_DIV    = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  typedef enum logic [3:0] {
    ST_WU, ST_UU, ST_WUU, ST_WV, ST_WUV,
    ST_DET_A, ST_DET_B, ST_N1_A, ST_N1_B, ST_N2_A, ST_N2_B
  } step_t;

  state_t state;
  state_t state_next;
  step_t  step;
  cmd_t   cur;
  logic   plane;
  logic   plane_done;
  logic   next_plane;

  logic signed [63:0] sums [2][5];
  logic signed [31:0] coef [2][2];
  logic [1:0]         sing;

  logic signed [63:0] t_wu;
  logic signed [63:0] t_uu;
  logic signed [63:0] mq;
  logic signed [63:0] mq_next;
  logic signed [63:0] op_a;
  logic signed [63:0] op_b;
  logic signed [63:0] w_ext;
  logic signed [63:0] u_ext;
  logic signed [63:0] v_ext;

  logic signed [PROD_W-1:0] pw;
  logic signed [PROD_W-1:0] pw_next;
  logic signed [PROD_W-1:0] pa;
  logic signed [PROD_W-1:0] det;
  logic signed [PROD_W-1:0] n1;
  logic signed [PROD_W-1:0] n2;

  logic         mul_start;
  logic         mul_done;
  logic [127:0] mul_mag;
  logic [127:0] mshift;
  logic         mul_neg;
  logic         movf;

  logic               div_start;
  logic [1:0]         div_done;
  logic signed [31:0] quot0;
  logic signed [31:0] quot1;

  fit_t res;
  logic res_valid;
  logic res_we;

  wlfa_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (op_a),
    .b     (op_b),
    .done  (mul_done),
    .mag   (mul_mag),
    .neg   (mul_neg)
  );

  wlfa_div #(.FRAC_BITS(FRAC_BITS)) u_div_icpt (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (n1),
    .den   (det),
    .done  (div_done[0]),
    .quot  (quot0)
  );

  wlfa_div #(.FRAC_BITS(FRAC_BITS)) u_div_slope (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (n2),
    .den   (det),
    .done  (div_done[1]),
    .quot  (quot1)
  );

  always_comb begin
    if (plane) begin
      w_ext = {32'b0, cur.hit.sz_weight};
      u_ext = {{32{cur.hit.path_len[31]}}, cur.hit.path_len};
      v_ext = {{32{cur.hit.z_pos[31]}}, cur.hit.z_pos};
    end else begin
      w_ext = {32'b0, cur.hit.xy_weight};
      u_ext = {{32{cur.hit.conf_x[31]}}, cur.hit.conf_x};
      v_ext = {{32{cur.hit.conf_y[31]}}, cur.hit.conf_y};
    end
  end

  always_comb begin
    case (step)
      ST_WU:    begin op_a = w_ext;          op_b = u_ext;          end
      ST_UU:    begin op_a = u_ext;          op_b = u_ext;          end
      ST_WUU:   begin op_a = w_ext;          op_b = t_uu;           end
      ST_WV:    begin op_a = w_ext;          op_b = v_ext;          end
      ST_WUV:   begin op_a = t_wu;           op_b = v_ext;          end
      ST_DET_A: begin op_a = sums[plane][0]; op_b = sums[plane][2]; end
      ST_DET_B: begin op_a = sums[plane][1]; op_b = sums[plane][1]; end
      ST_N1_A:  begin op_a = sums[plane][3]; op_b = sums[plane][2]; end
      ST_N1_B:  begin op_a = sums[plane][4]; op_b = sums[plane][1]; end
      ST_N2_A:  begin op_a = sums[plane][4]; op_b = sums[plane][0]; end
      ST_N2_B:  begin op_a = sums[plane][3]; op_b = sums[plane][1]; end
      default:  begin op_a = '0;             op_b = '0;             end
    endcase
  end

  always_comb begin
    mshift  = mul_mag >> FRAC_BITS;
    movf    = |mshift[127:63];
    if (movf) begin
      mq_next = mul_neg ? {1'b1, {63{1'b0}}} : {1'b0, {63{1'b1}}};
    end else begin
      mq_next = mul_neg ? -mshift[63:0] : mshift[63:0];
    end
    pw_next = mul_neg ? -PROD_W'(mul_mag) : PROD_W'(mul_mag);
  end

  assign next_plane = !plane && cur.sz_en;
  assign res_we     = (state == S_DONE) && (!res_valid || pop);
  assign empty      = !res_valid;
  assign fit        = res;

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    plane_done = 1'b0;
    case (state)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = cmd.acc ? S_ISSUE : S_DONE;
        end
      end
      S_ISSUE: begin
        mul_start  = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        if (mul_done) begin
          state_next = S_POST;
        end
      end
      S_POST: begin
        if (step == ST_WUV && !cur.solving) begin
          plane_done = 1'b1;
        end else if (step == ST_N2_B) begin
          state_next = S_DSTART;
        end else begin
          state_next = S_ISSUE;
        end
      end
      S_DSTART: begin
        if (det == '0) begin
          plane_done = 1'b1;
        end else begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done[0]) begin
          plane_done = 1'b1;
        end
      end
      S_DONE: begin
        if (res_we) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (plane_done) begin
      state_next = next_plane ? S_ISSUE : S_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      for (int p = 0; p < 2; p++) begin
        for (int i = 0; i < 5; i++) begin
          sums[p][i] <= '0;
        end
        coef[p][0] <= '0;
        coef[p][1] <= '0;
      end
    end else begin
      state <= state_next;
      if (res_we) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty && cmd.start) begin
            for (int p = 0; p < 2; p++) begin
              for (int i = 0; i < 5; i++) begin
                sums[p][i] <= '0;
              end
              coef[p][0] <= '0;
              coef[p][1] <= '0;
            end
          end
        end
        S_POST: begin
          case (step)
            ST_WU: begin
              sums[plane][0] <= sat_add64(sums[plane][0], w_ext);
              sums[plane][1] <= sat_add64(sums[plane][1], mq);
            end
            ST_WUU:  sums[plane][2] <= sat_add64(sums[plane][2], mq);
            ST_WV:   sums[plane][3] <= sat_add64(sums[plane][3], mq);
            ST_WUV:  sums[plane][4] <= sat_add64(sums[plane][4], mq);
            default: ;
          endcase
        end
        S_DIV: begin
          if (div_done[0]) begin
            coef[plane][0] <= quot0;
            coef[plane][1] <= quot1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (!q_empty) begin
          cur   <= cmd;
          plane <= 1'b0;
          step  <= ST_WU;
          sing  <= '0;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          mq <= mq_next;
          pw <= pw_next;
        end
      end
      S_POST: begin
        case (step)
          ST_WU:                      t_wu <= mq;
          ST_UU:                      t_uu <= mq;
          ST_DET_A, ST_N1_A, ST_N2_A: pa   <= pw;
          ST_DET_B:                   det  <= pa - pw;
          ST_N1_B:                    n1   <= pa - pw;
          ST_N2_B:                    n2   <= pa - pw;
          default: ;
        endcase
        if (!plane_done) begin
          step <= step_t'(step + 4'd1);
        end
      end
      S_DSTART: begin
        if (det == '0) begin
          sing[plane] <= 1'b1;
        end
      end
      default: ;
    endcase
    if (plane_done) begin
      plane <= 1'b1;
      step  <= ST_WU;
    end
    if (res_we) begin
      res.xy_intercept <= coef[0][0];
      res.xy_slope     <= coef[0][1];
      res.sz_intercept <= coef[1][0];
      res.sz_slope     <= coef[1][1];
      res.xy_singular  <= sing[0];
      res.sz_singular  <= sing[1];
      res.fit_solved   <= cur.solving;
      res.hits_so_far  <= cur.hits;
    end
  end

  a_div_nonzero_det: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (det != '0))
    else $error("division started with a zero determinant");

  a_sing_needs_solve: assert property (@(posedge clk) disable iff (rst)
    res_we |-> ((!sing[0] && !sing[1]) || cur.solving))
    else $error("singular flag raised on a hit that does not solve");

  a_sz_sing_enabled: assert property (@(posedge clk) disable iff (rst)
    (res_we && sing[1]) |-> cur.sz_en)
    else $error("sz singular flag raised with the sz plane disabled");

  a_mul_latency: assert property (@(posedge clk) disable iff (rst)
    mul_start |=> ((state == S_MUL) && !mul_done))
    else $error("multiplier finished too early");

  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    div_done[0] |-> div_done[1])
    else $error("dividers out of step");

endmodule

// File: src/weighted_line_fit_accumulator.sv
// ----------------------------------------------------------------------------
// Weighted line fit accumulator
// An accepted hit enters a two-entry command queue at its accepting edge.
// A hit below the minimum count goes from the queue straight to the result register.
// Each multiply runs its partial products through the shared 32x32 multiplier; a plane
// gets its moment products, then determinant and numerator products and the dividers.
// One hit at a time; rst clears control, settings, counts, sums and coefficients.
// ----------------------------------------------------------------------------
module weighted_line_fit_accumulator #(
  parameter int FRAC_BITS = wlfa_pkg::FRAC_BITS_DEF,
  parameter int MAX_HITS  = wlfa_pkg::MAX_HITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  wlfa_pkg::hit_t                    hit,
  output logic                              empty,
  input  logic                              pop,
  output wlfa_pkg::fit_t                    fit,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wlfa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wlfa_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import wlfa_pkg::*;

  cmd_t front_cmd;
  cmd_t back_cmd;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;

  wlfa_front #(.MAX_HITS(MAX_HITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .hit       (hit),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_push    (q_push),
    .q_full    (q_full),
    .cmd       (front_cmd)
  );

  wlfa_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .full  (q_full),
    .din   (front_cmd),
    .pop   (q_pop),
    .empty (q_empty),
    .dout  (back_cmd)
  );

  wlfa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .cmd     (back_cmd),
    .empty   (empty),
    .pop     (pop),
    .fit     (fit)
  );

endmodule

// File: sim/weighted_line_fit_accumulator_chk.sv
// ----------------------------------------------------------------------------
// Line fit accumulator checker
// Watches the hit, fit and register channels, keeps its own copy of the track
// sums, coefficients and settings, predicts one fit per accepted hit and
// compares every popped fit with the oldest prediction.
// ----------------------------------------------------------------------------
module weighted_line_fit_accumulator_chk
  import wlfa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic                  full,
  input  hit_t                  hit,
  input  logic                  empty,
  input  logic                  pop,
  input  fit_t                  fit,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    fits_waiting,
  output int                    fits_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [255:0] wide_t;
  typedef logic signed [63:0] sum_t;

  localparam sum_t SUM_MAX = {1'b0, {63{1'b1}}};
  localparam sum_t SUM_MIN = {1'b1, {63{1'b0}}};

  logic [7:0]         min_hits;
  logic               sz_enable;
  logic [7:0]         hit_count;
  sum_t               moments [2][5];
  logic signed [31:0] coeffs [2][2];
  fit_t               expected_fits [$];

  function automatic sum_t q_product(sum_t a, sum_t b);
    wide_t wa, wb, p, mag;
    logic  neg;
    wa = a;
    wb = b;
    p = wa * wb;
    neg = p[255];
    mag = neg ? -p : p;
    mag = mag >> 16;
    if (mag > wide_t'(SUM_MAX)) return neg ? SUM_MIN : SUM_MAX;
    return neg ? -mag[63:0] : mag[63:0];
  endfunction

  function automatic sum_t add_clamped(sum_t a, sum_t b);
    sum_t s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) return a[63] ? SUM_MIN : SUM_MAX;
    return s;
  endfunction

  function automatic logic signed [31:0] q_quotient(wide_t num, wide_t den);
    wide_t n, d, q;
    logic  neg;
    neg = num[255] ^ den[255];
    n = num[255] ? -num : num;
    d = den[255] ? -den : den;
    n = n << 16;
    q = n / d;
    if (neg) return (q > 256'h8000_0000) ? 32'sh8000_0000 : -q[31:0];
    return (q > 256'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q[31:0];
  endfunction

  function automatic void add_moments(int plane, sum_t w, sum_t u, sum_t v);
    sum_t wu;
    wu = q_product(w, u);
    moments[plane][0] = add_clamped(moments[plane][0], w);
    moments[plane][1] = add_clamped(moments[plane][1], wu);
    moments[plane][2] = add_clamped(moments[plane][2], q_product(w, q_product(u, u)));
    moments[plane][3] = add_clamped(moments[plane][3], q_product(w, v));
    moments[plane][4] = add_clamped(moments[plane][4], q_product(wu, v));
  endfunction

  function automatic logic solve_line(int plane);
    wide_t s11, s12, s22, g1, g2, det;
    s11 = moments[plane][0];
    s12 = moments[plane][1];
    s22 = moments[plane][2];
    g1  = moments[plane][3];
    g2  = moments[plane][4];
    det = s11 * s22 - s12 * s12;
    if (det == 0) return 1'b1;
    coeffs[plane][0] = q_quotient(g1 * s22 - g2 * s12, det);
    coeffs[plane][1] = q_quotient(g2 * s11 - g1 * s12, det);
    return 1'b0;
  endfunction

  function automatic void clear_track();
    hit_count = '0;
    for (int p = 0; p < 2; p++) begin
      for (int k = 0; k < 5; k++) moments[p][k] = '0;
      coeffs[p][0] = '0;
      coeffs[p][1] = '0;
    end
  endfunction

  function automatic fit_t predict_fit(hit_t h);
    fit_t r;
    sum_t w, u, v;
    r = '0;
    if (h.start_track) clear_track();
    if (hit_count < 8'd255) hit_count++;
    if (hit_count >= min_hits) begin
      r.fit_solved = hit_count > min_hits;
      w = {32'd0, h.xy_weight};
      u = h.conf_x;
      v = h.conf_y;
      add_moments(0, w, u, v);
      if (r.fit_solved) r.xy_singular = solve_line(0);
      if (sz_enable) begin
        w = {32'd0, h.sz_weight};
        u = h.path_len;
        v = h.z_pos;
        add_moments(1, w, u, v);
        if (r.fit_solved) r.sz_singular = solve_line(1);
      end
    end
    r.xy_intercept = coeffs[0][0];
    r.xy_slope     = coeffs[0][1];
    r.sz_intercept = coeffs[1][0];
    r.sz_slope     = coeffs[1][1];
    r.hits_so_far  = hit_count;
    return r;
  endfunction

  assign fits_waiting = expected_fits.size();

  always @(posedge clk) begin
    fit_t want;
    if (rst) begin
      min_hits = MIN_HITS_RST;
      sz_enable = SZ_EN_RST;
      clear_track();
      expected_fits.delete();
      fail_count <= 0;
      fits_checked <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MIN_HITS) min_hits = cfg_data;
        else if (cfg_index == REG_SZ_ENABLE) sz_enable = cfg_data[0];
      end
      if (pop && !empty) begin
        if (expected_fits.size() == 0) begin
          if (fail_count < 10) $display("Fit transaction with no hit pending: %p", fit);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_fits.pop_front();
          fits_checked <= fits_checked + 1;
          if (fit !== want) begin
            if (fail_count < 10) begin
              $display("Fit mismatch at %0t", $realtime);
              $display("  expected %p", want);
              $display("  actual   %p", fit);
            end
            fail_count <= fail_count + 1;
          end
        end
      end
      if (push && !full) expected_fits.push_back(predict_fit(hit));
    end
  end

endmodule

// File: sim/weighted_line_fit_accumulator_tb.sv
// ----------------------------------------------------------------------------
// Line fit accumulator testbench
// Feeds directed and random tracks of hits under several register settings,
// pops fits with random stalls and leaves the checking of fits to the checker.
// ----------------------------------------------------------------------------
module weighted_line_fit_accumulator_tb;
  import wlfa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE      = 300;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  push = 1'b0;
  logic                  full;
  hit_t                  hit = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  fit_t                  fit;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    fail_count, fits_waiting, fits_checked;
  int                    hits_sent = 0, tracks = 0, stall_cycles = 0;
  bit                    quiet = 1'b0;

  always #10 clk = ~clk;

  weighted_line_fit_accumulator DUT (.*);
  weighted_line_fit_accumulator_chk checker_i (.*);

  always @(posedge clk) begin
    if (rst) pop <= 1'b0;
    else pop <= quiet || ($urandom_range(0, 99) >= 17);
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("weighted_line_fit_accumulator_tb: done, errors");
        $finish;
      end
    end
  end

  function automatic logic [31:0] near_coord();
    return $urandom_range(0, 32'h7F_FFFF) - 32'h40_0000;
  endfunction

  function automatic hit_t random_hit(bit first);
    hit_t h;
    int   mode;
    mode = $urandom_range(0, 19);
    h.start_track = first;
    if (mode < 2) begin
      h.xy_weight = $urandom;
      h.conf_x = $urandom;
      h.conf_y = $urandom;
      h.sz_weight = $urandom;
      h.path_len = $urandom;
      h.z_pos = $urandom;
    end else begin
      h.xy_weight = (mode == 2) ? 32'd0 : $urandom_range(32'h4000, 32'h4_0000);
      h.sz_weight = (mode == 3) ? 32'd0 : $urandom_range(32'h4000, 32'h4_0000);
      h.conf_x = near_coord();
      h.conf_y = near_coord();
      h.path_len = (mode == 4) ? 32'sh5_0000 : near_coord();
      h.z_pos = near_coord();
    end
    return h;
  endfunction

  function automatic hit_t make_hit(bit first, logic [31:0] w, logic [31:0] x,
                                    logic [31:0] y, logic [31:0] sw,
                                    logic [31:0] s, logic [31:0] z);
    hit_t h;
    h = '{first, w, x, y, sw, s, z};
    return h;
  endfunction

  task automatic send_hit(hit_t h);
    if (h.start_track) tracks++;
    push <= 1'b1;
    hit <= h;
    do @(posedge clk); while (full);
    hits_sent++;
    if (!quiet && $urandom_range(0, 99) < 17) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (fits_waiting != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [7:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_tracks(int count);
    int n, len;
    n = 0;
    while (n < count) begin
      len = $urandom_range(1, 10);
      for (int i = 0; i < len; i++) begin
        send_hit(random_hit(i == 0 || $urandom_range(0, 49) == 0));
        n++;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A clean line in both planes: v = 1 + 2u.
    for (int i = 0; i < 5; i++) begin
      send_hit(make_hit(i == 0, 32'h1_0000, i << 16, (2 * i + 1) << 16,
                        32'h1_0000, i << 16, (2 * i + 1) << 16));
    end
    // Zero weights and repeated abscissas leave both determinants at zero.
    for (int i = 0; i < 4; i++) begin
      send_hit(make_hit(i == 0, 32'd0, i << 16, 32'h3_0000,
                        32'h1_0000, 32'h5_0000, i << 16));
    end
    // Field extremes drive the sums and quotients into saturation.
    for (int i = 0; i < 6; i++) begin
      send_hit(make_hit(i == 0, 32'hFFFF_FFFF,
                        i[0] ? 32'h7FFF_FFFF : 32'h8000_0000,
                        i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF,
                        i[1] ? 32'hFFFF_FFFF : 32'h0000_0001,
                        i[0] ? 32'h8000_0000 : 32'd0,
                        32'h7FFF_FFFF));
    end

    write_reg(REG_MIN_HITS, 8'd0);
    write_reg(REG_SZ_ENABLE, 8'd0);
    for (int i = 0; i < 5; i++) send_hit(random_hit(i == 0));

    // Hit count saturation with the largest minimum.
    write_reg(REG_MIN_HITS, 8'd255);
    write_reg(REG_SZ_ENABLE, 8'd1);
    quiet = 1'b1;
    for (int i = 0; i < 270; i++) send_hit(random_hit(i == 0));
    quiet = 1'b0;

    write_reg(REG_MIN_HITS, 8'd2);
    random_tracks(400);
    write_reg(REG_MIN_HITS, 8'd1);
    write_reg(REG_SZ_ENABLE, 8'd0);
    random_tracks(350);
    write_reg(REG_MIN_HITS, 8'd4);
    write_reg(REG_SZ_ENABLE, 8'd1);
    random_tracks(350);
    write_reg(REG_MIN_HITS, 8'($urandom_range(0, 6)));
    write_reg(REG_SZ_ENABLE, 8'($urandom_range(0, 1)));
    random_tracks(350);

    wait_idle();
    $display("Sent %0d hits in %0d tracks and checked %0d fits,", hits_sent, tracks,
             fits_checked);
    $display("with minimum hit counts from 0 to 255 and the sz plane on and off.");
    if (fail_count == 0) begin
      $display("weighted_line_fit_accumulator_tb: done, clean");
    end else begin
      $display("Mismatches: %0d", fail_count);
      $display("weighted_line_fit_accumulator_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: sim.f
src/wlfa_pkg.sv
src/wlfa_front.sv
src/wlfa_queue.sv
src/wlfa_mul.sv
src/wlfa_div.sv
src/wlfa_back.sv
src/weighted_line_fit_accumulator.sv
sim/weighted_line_fit_accumulator_chk.sv
sim/weighted_line_fit_accumulator_tb.sv
